// ----- sv/twf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twf_pkg
// Shared types and constants of the tile fragment walker.
// ----------------------------------------------------------------------------
package twf_pkg;

  localparam int TN_W     = 24;
  localparam int DIM_W    = 13;
  localparam int COORD_W  = 12;
  localparam int TW_W     = 8;
  localparam int TH_W     = 5;
  localparam int FW_W     = 7;
  localparam int FH_W     = 4;
  localparam int SEED_W   = 24;
  localparam int CNT_W    = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 13;
  localparam int DIV_STEPS = TN_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam int FRAG_MAX_DEF    = 64;
  localparam int SQUARE_SIDE_DEF = 8;
  localparam int MAX_RES_DEF     = 4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TILE_WIDTH   = 3'd0,
    REG_TILE_HEIGHT  = 3'd1,
    REG_IMAGE_WIDTH  = 3'd2,
    REG_IMAGE_HEIGHT = 3'd3,
    REG_SQUARE_MODE  = 3'd4,
    REG_STEREO_ON    = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    DIV_TILE_ROWS = 1'b0,
    DIV_TILE_SPLIT = 1'b1
  } div_sel_e;

  typedef struct packed {
    logic [TN_W-1:0] tile_number;
  } tile_t;

  typedef struct packed {
    logic                eye;
    logic [COORD_W-1:0]  x_first;
    logic [COORD_W-1:0]  y_first;
    logic [FW_W-1:0]     frag_width;
    logic [FH_W-1:0]     frag_height;
    logic [FW_W-1:0]     pixel_count;
    logic [SEED_W-1:0]   sample_seed;
    logic                clipped;
    logic                bad_tile;
    logic                last;
  } frag_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_e div_sel;
    logic     split_load;
    logic     mul_load;
    logic     setup;
    logic     emit;
    logic     emit_bad;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic bad;
    logic out_free;
    logic frag_last;
  } sts_t;

endpackage

// ----- sv/twf_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twf_if
// Valid/ready channels of the tile fragment walker.
// ----------------------------------------------------------------------------
interface twf_tile_if;
  logic            valid;
  logic            ready;
  twf_pkg::tile_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface twf_frag_if;
  logic            valid;
  logic            ready;
  twf_pkg::frag_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface twf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [twf_pkg::CFG_IDX_W-1:0]     index;
  logic [twf_pkg::CFG_DAT_W-1:0]     wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// ----- sv/twf_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module twf_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [twf_pkg::TN_W-1:0]     dividend_i,
  input  logic [twf_pkg::DIM_W-1:0]    divisor_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [twf_pkg::TN_W-1:0]     quot_o,
  output logic [twf_pkg::DIM_W-1:0]    rem_o
);

  logic [twf_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                          done_q, done_d;
  logic [twf_pkg::TN_W-1:0]      q_q, q_d;
  logic [twf_pkg::DIM_W-1:0]     r_q, r_d;
  logic [twf_pkg::DIM_W-1:0]     dvs_q, dvs_d;
  logic [twf_pkg::DIM_W:0]       trial;
  logic                          fits;

  assign trial = {r_q, q_q[twf_pkg::TN_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    q_d    = q_q;
    r_d    = r_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      cnt_d = twf_pkg::DIV_CNT_W'(twf_pkg::DIV_STEPS);
      q_d   = dividend_i;
      r_d   = '0;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == twf_pkg::DIV_CNT_W'(1));
      q_d    = {q_q[twf_pkg::TN_W-2:0], fits};
      r_d    = fits ? twf_pkg::DIM_W'(trial - {1'b0, dvs_q})
                    : trial[twf_pkg::DIM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    r_q   <= r_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = (cnt_q != '0);
  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;

endmodule

// ----- sv/twf_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twf_datapath
// Configuration registers, tile split, clipping, fragment walk and output word.
// ----------------------------------------------------------------------------
module twf_datapath #(
  parameter int FRAG_MAX    = twf_pkg::FRAG_MAX_DEF,
  parameter int SQUARE_SIDE = twf_pkg::SQUARE_SIDE_DEF,
  parameter int MAX_RES     = twf_pkg::MAX_RES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [twf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [twf_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  twf_pkg::tile_t                tile_i,
  input  twf_pkg::cmd_t                 cmd_i,
  output twf_pkg::sts_t                 sts_o,
  output logic                          frag_valid_o,
  input  logic                          frag_ready_i,
  output twf_pkg::frag_t                frag_o
);

  localparam int DW   = twf_pkg::DIM_W;
  localparam int XPW  = twf_pkg::TN_W + twf_pkg::TW_W;
  localparam int YPW  = DW + twf_pkg::TH_W;
  localparam int PIXW = twf_pkg::FW_W + twf_pkg::FH_W;
  localparam logic [DW-1:0] LineStep = DW'(FRAG_MAX);
  localparam logic [DW-1:0] SqStep   = DW'(SQUARE_SIDE);
  localparam logic [DW-1:0] ResMax   = DW'(MAX_RES);

  // configuration
  logic [twf_pkg::TW_W-1:0] tw_q;
  logic [twf_pkg::TH_W-1:0] th_q;
  logic [DW-1:0]            iw_q, ih_q;
  logic                     square_q, stereo_q;
  logic [DW-1:0]            iw_sat, ih_sat;
  logic                     zero_size;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tw_q     <= twf_pkg::TW_W'(8);
      th_q     <= twf_pkg::TH_W'(8);
      iw_q     <= DW'(512);
      ih_q     <= DW'(512);
      square_q <= 1'b0;
      stereo_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (twf_pkg::cfg_reg_e'(cfg_idx_i))
        twf_pkg::REG_TILE_WIDTH:   tw_q     <= cfg_data_i[twf_pkg::TW_W-1:0];
        twf_pkg::REG_TILE_HEIGHT:  th_q     <= cfg_data_i[twf_pkg::TH_W-1:0];
        twf_pkg::REG_IMAGE_WIDTH:  iw_q     <= cfg_data_i;
        twf_pkg::REG_IMAGE_HEIGHT: ih_q     <= cfg_data_i;
        twf_pkg::REG_SQUARE_MODE:  square_q <= cfg_data_i[0];
        twf_pkg::REG_STEREO_ON:    stereo_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign iw_sat    = (iw_q > ResMax) ? ResMax : iw_q;
  assign ih_sat    = (ih_q > ResMax) ? ResMax : ih_q;
  assign zero_size = (tw_q == '0) || (th_q == '0) || (iw_sat == '0) || (ih_sat == '0);

  // tile split through the shared divider
  logic [twf_pkg::TN_W-1:0] tn_q;
  logic [twf_pkg::TN_W-1:0] div_dividend, div_quot;
  logic [DW-1:0]            div_divisor, div_rem;
  logic                     div_busy, div_done;
  logic [DW:0]              rows_num;

  assign rows_num     = {1'b0, ih_sat} + (DW+1)'(th_q) - (DW+1)'(1);
  assign div_dividend = (cmd_i.div_sel == twf_pkg::DIV_TILE_ROWS)
                        ? twf_pkg::TN_W'(rows_num) : tn_q;
  assign div_divisor  = (cmd_i.div_sel == twf_pkg::DIV_TILE_ROWS)
                        ? DW'(th_q) : div_quot[DW-1:0];

  twf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  logic [twf_pkg::TN_W-1:0]               xt_q;
  logic [DW-1:0]                          yt_q;
  logic [twf_pkg::TN_W+twf_pkg::TW_W-1:0] xprod_q;
  logic [DW+twf_pkg::TH_W-1:0]            yprod_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) tn_q <= tile_i.tile_number;
    if (cmd_i.split_load) begin
      xt_q <= div_quot;
      yt_q <= div_rem;
    end
    if (cmd_i.mul_load) begin
      xprod_q <= XPW'(xt_q) * XPW'(tw_q);
      yprod_q <= YPW'(yt_q) * YPW'(th_q);
    end
  end

  // clipped tile rectangle
  logic [DW-1:0] xs, ys, xe_sum, ye_sum, xe, ye;
  assign xs     = xprod_q[DW-1:0];
  assign ys     = yprod_q[DW-1:0];
  assign xe_sum = xs + DW'(tw_q);
  assign ye_sum = ys + DW'(th_q);
  assign xe     = (xe_sum > iw_sat) ? iw_sat : xe_sum;
  assign ye     = (ye_sum > ih_sat) ? ih_sat : ye_sum;

  // fragment walk
  logic [DW-1:0]             xs_q, xe_q, ys_q, ye_q, x_q, y_q, iws_q;
  logic                      eye_q;
  logic [twf_pkg::CNT_W-1:0] cnt_q;
  logic [DW-1:0]             x_step, y_step, x_nx, y_nx, w_rem, h_rem, w_max;
  logic [DW-1:0]             w_sel, h_sel;
  logic                      x_wrap, y_wrap, tile_end, frag_last;
  logic [twf_pkg::FW_W+twf_pkg::FH_W-1:0] pix;
  logic [2*DW-1:0]           seed_full;
  twf_pkg::frag_t            frag;
  twf_pkg::frag_t            frag_bad;

  assign x_step   = square_q ? SqStep : LineStep;
  assign y_step   = square_q ? SqStep : DW'(1);
  assign x_nx     = x_q + x_step;
  assign y_nx     = y_q + y_step;
  assign x_wrap   = x_nx >= xe_q;
  assign y_wrap   = y_nx >= ye_q;
  assign tile_end = x_wrap && y_wrap && (!stereo_q || eye_q);
  assign frag_last = tile_end || (cnt_q == '1);

  assign w_rem = xe_q - x_q;
  assign h_rem = ye_q - y_q;
  assign w_max = square_q ? SqStep : LineStep;
  assign w_sel = (w_rem > w_max) ? w_max : w_rem;
  assign h_sel = !square_q ? DW'(1) : ((h_rem > SqStep) ? SqStep : h_rem);
  assign pix   = PIXW'(w_sel[twf_pkg::FW_W-1:0]) * PIXW'(h_sel[twf_pkg::FH_W-1:0]);
  assign seed_full = (2*DW)'(x_q) * (2*DW)'(iws_q) + (2*DW)'(y_q);

  always_comb begin
    frag             = '0;
    frag.eye         = eye_q;
    frag.x_first     = x_q[twf_pkg::COORD_W-1:0];
    frag.y_first     = y_q[twf_pkg::COORD_W-1:0];
    frag.frag_width  = w_sel[twf_pkg::FW_W-1:0];
    frag.frag_height = h_sel[twf_pkg::FH_W-1:0];
    frag.pixel_count = pix[twf_pkg::FW_W-1:0];
    frag.sample_seed = seed_full[twf_pkg::SEED_W-1:0];
    frag.clipped     = square_q && ((w_sel != SqStep) || (h_sel != SqStep));
    frag.last        = frag_last;
  end

  always_comb begin
    frag_bad          = '0;
    frag_bad.bad_tile = 1'b1;
    frag_bad.last     = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      xs_q  <= xs;
      xe_q  <= xe;
      ys_q  <= ys;
      ye_q  <= ye;
      x_q   <= xs;
      y_q   <= ys;
      iws_q <= iw_sat;
      eye_q <= 1'b0;
      cnt_q <= '0;
    end else if (cmd_i.emit) begin
      cnt_q <= cnt_q + 1'b1;
      if (x_wrap) begin
        x_q <= xs_q;
        if (y_wrap) begin
          y_q   <= ys_q;
          eye_q <= 1'b1;
        end else begin
          y_q <= y_nx;
        end
      end else begin
        x_q <= x_nx;
      end
    end
  end

  // output word register
  logic           out_valid_q;
  twf_pkg::frag_t out_q;
  logic           out_free;

  assign out_free = !out_valid_q || frag_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.emit_bad) begin
      out_valid_q <= 1'b1;
    end else if (frag_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= frag;
    end else if (cmd_i.emit_bad) begin
      out_q <= frag_bad;
    end
  end

  assign frag_valid_o    = out_valid_q;
  assign frag_o          = out_q;
  assign sts_o.div_busy  = div_busy;
  assign sts_o.div_done  = div_done;
  assign sts_o.bad       = zero_size ||
                           (xprod_q >= (twf_pkg::TN_W+twf_pkg::TW_W)'(iw_sat));
  assign sts_o.out_free  = out_free;
  assign sts_o.frag_last = frag_last;

endmodule

// ----- sv/twf_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twf_ctrl
// Sequencer: tile split, range check, then one fragment word per cycle while the output register is free.
// ----------------------------------------------------------------------------
module twf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  twf_pkg::sts_t sts_i,
  output twf_pkg::cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIVY  = 7'b0000010,
    S_DIVT  = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_RANGE = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_BAD   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.div_sel = twf_pkg::DIV_TILE_ROWS;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load      = 1'b1;
          cmd_o.div_start = 1'b1;
          state_d         = S_DIVY;
        end
      end
      S_DIVY: begin
        if (sts_i.div_done) begin
          cmd_o.div_sel   = twf_pkg::DIV_TILE_SPLIT;
          cmd_o.div_start = 1'b1;
          state_d         = S_DIVT;
        end
      end
      S_DIVT: begin
        if (sts_i.div_done) begin
          cmd_o.split_load = 1'b1;
          state_d          = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_load = 1'b1;
        state_d        = S_RANGE;
      end
      S_RANGE: begin
        if (sts_i.bad) begin
          state_d = S_BAD;
        end else begin
          cmd_o.setup = 1'b1;
          state_d     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.frag_last) state_d = S_IDLE;
        end
      end
      S_BAD: begin
        if (sts_i.out_free) begin
          cmd_o.emit_bad = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ----- sv/tile_fragment_walker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_fragment_walker
// Splits a tile number into a clipped tile rectangle and walks its fragments.
//
// Channels: tile_i takes one tile number per word; frag_o gives the fragment
// words of that tile, the final one flagged by last; cfg_i writes the six
// setup registers by index and is always ready. Write cfg_i only while idle.
// A tile number beyond the image gives one word with bad_tile and last set.
// The tile split runs two passes of a 24-step restoring divider (tile-row
// count, then column and row), followed by a split load, a multiply and a
// range check with clipping. Fragments then leave one per cycle while frag_o
// does not stall, at most 64 per tile. The next tile is accepted once the
// last word of the current one sits in the output register. A stall on
// frag_o holds the walk; the output register keeps the word until it is
// taken. Reset returns the setup registers to their defaults and leaves the
// block idle with no word pending.
// ----------------------------------------------------------------------------
module tile_fragment_walker #(
  parameter int FRAG_MAX    = twf_pkg::FRAG_MAX_DEF,
  parameter int SQUARE_SIDE = twf_pkg::SQUARE_SIDE_DEF,
  parameter int MAX_RES     = twf_pkg::MAX_RES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  twf_tile_if.sink   tile_i,
  twf_frag_if.source frag_o,
  twf_cfg_if.sink    cfg_i
);

  twf_pkg::cmd_t cmd;
  twf_pkg::sts_t sts;

  assign cfg_i.ready = 1'b1;

  twf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (tile_i.valid),
    .in_ready_o (tile_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  twf_datapath #(
    .FRAG_MAX    (FRAG_MAX),
    .SQUARE_SIDE (SQUARE_SIDE),
    .MAX_RES     (MAX_RES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_i.valid),
    .cfg_idx_i    (cfg_i.index),
    .cfg_data_i   (cfg_i.wdata),
    .tile_i       (tile_i.data),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .frag_valid_o (frag_o.valid),
    .frag_ready_i (frag_o.ready),
    .frag_o       (frag_o.data)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tile_i.valid && tile_i.ready |=> !tile_i.ready)
    else $error("tile accepted twice in a row");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider restarted while busy");

  a_emit_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit || cmd.emit_bad) |-> sts.out_free)
    else $error("word loaded over a pending word");

  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frag_o.valid && frag_o.data.bad_tile |-> frag_o.data.last)
    else $error("bad tile word without last");

endmodule
